// ===== design/sorted_key_table_assert.svh =====
// Assertion macros shared by the sorted key table modules.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define SKT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_key_table: assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define SKT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_key_table: assertion failed");

`endif

// ===== design/skt_pkg.sv =====
// Types and constants shared by the sorted key table modules.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int KEY_W    = 16;
  localparam int VALUE_W  = 14;
  localparam int NAME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value_pct;
    logic [NAME_W-1:0]  name_ref;
  } entry_t;

  typedef struct packed {
    logic ins_en;
    logic del_en;
  } skt_ctl_t;

endpackage

// ===== design/skt_if.sv =====
// Request and result channel interfaces of the sorted key table.
`timescale 1ns / 1ps

interface skt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [skt_pkg::KEY_W-1:0]   key;
  logic [skt_pkg::VALUE_W-1:0] value_pct;
  logic [skt_pkg::NAME_W-1:0]  name_ref;

  modport source (output valid, output cmd, output key, output value_pct,
                  output name_ref, input ready);
  modport sink (input valid, input cmd, input key, input value_pct,
                input name_ref, output ready);
endinterface

interface skt_out_if;
  logic                         valid;
  logic                         ready;
  logic [skt_pkg::STATUS_W-1:0] status;
  logic [skt_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output count, input ready);
  modport sink (input valid, input status, input count, output ready);
endinterface

// ===== design/sorted_key_table.sv =====
// Sorted key table: fixed-capacity table kept in ascending key order.
// Requests arrive on in_req: cmd selects insert or delete, key orders and
// matches entries, value_pct and name_ref are stored on insert. An insert
// goes after every entry with a key not greater than its own; a delete
// removes the first entry with an equal key and closes the gap.
// Each request yields one result on out_res: status (done, table full,
// key not found) and the entry count after the request.
// A request is taken into the request register and executed once the
// result register is free, when every cell of the chain compares in
// parallel and shifts by one slot. The result is registered, and a new
// request is taken only after the previous one has executed, set by the
// single request register in front of the cell chain.
// The result register is separate from the request register, so a
// request may be accepted while a result waits; a stalled receiver holds
// the next request in the request register until the result is taken.
// Synchronous reset empties the table at once; cell contents are not
// cleared, only the count.
`timescale 1ns / 1ps

`include "sorted_key_table_assert.svh"

module sorted_key_table #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  skt_in_if.sink    in_req,
  skt_out_if.source out_res
);

  localparam int CLOG_W = $clog2(CAPACITY + 1);
  localparam int CNT_W  = (CLOG_W > skt_pkg::COUNT_W) ? CLOG_W : skt_pkg::COUNT_W;

  logic                                  busy_r, busy_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]                      count_r, count_nxt;
  logic                                  req_cmd_r;
  skt_pkg::entry_t                       req_item_r;
  logic [skt_pkg::STATUS_W-1:0]          out_status_r, out_status_nxt;
  logic [skt_pkg::COUNT_W-1:0]           out_count_r;
  logic                                  accept;
  logic                                  exec;
  logic                                  full;
  logic                                  found;
  skt_pkg::skt_ctl_t                     ctl;

  assign in_req.ready = !busy_r;
  assign accept       = in_req.valid && in_req.ready;
  assign exec         = busy_r && (!out_valid_r || out_res.ready);
  assign full         = count_r == CNT_W'(CAPACITY);

  skt_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .item  (req_item_r),
    .count (count_r),
    .found (found)
  );

  always_comb begin
    ctl.ins_en     = 1'b0;
    ctl.del_en     = 1'b0;
    count_nxt      = count_r;
    out_status_nxt = skt_pkg::ST_DONE;
    unique case (req_cmd_r)
      skt_pkg::CMD_INSERT: begin
        if (full) begin
          out_status_nxt = skt_pkg::ST_FULL;
        end else begin
          ctl.ins_en = exec;
          if (exec) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      skt_pkg::CMD_DELETE: begin
        if (!found) begin
          out_status_nxt = skt_pkg::ST_NOT_FOUND;
        end else begin
          ctl.del_en = exec;
          if (exec) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        out_status_nxt = skt_pkg::ST_DONE;
      end
    endcase

    busy_nxt = busy_r;
    if (exec) begin
      busy_nxt = 1'b0;
    end else if (accept) begin
      busy_nxt = 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd_r            <= in_req.cmd;
      req_item_r.key       <= in_req.key;
      req_item_r.value_pct <= in_req.value_pct;
      req_item_r.name_ref  <= in_req.name_ref;
    end
    if (exec) begin
      out_status_r <= out_status_nxt;
      out_count_r  <= count_nxt[skt_pkg::COUNT_W-1:0];
    end
  end

  assign out_res.valid  = out_valid_r;
  assign out_res.status = out_status_r;
  assign out_res.count  = out_count_r;

  `SKT_ASSERT_IMP(a_cnt_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SKT_ASSERT_IMP(a_out_cnt, out_valid_r, out_count_r == count_r[skt_pkg::COUNT_W-1:0])
  `SKT_ASSERT_NXT(a_cnt_hold, !exec, $stable(count_r))

endmodule

// ===== design/skt_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps

module skt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  skt_pkg::skt_ctl_t ctl,
  input  skt_pkg::entry_t   item,
  input  logic [CNT_W-1:0]  count,
  input  skt_pkg::entry_t   left_ent,
  input  logic              left_after,
  input  logic              left_ge,
  input  skt_pkg::entry_t   right_ent,
  output skt_pkg::entry_t   ent,
  output logic              after,
  output logic              ge,
  output logic              hit
);

  skt_pkg::entry_t ent_r;
  skt_pkg::entry_t ent_nxt;
  logic            occ;

  assign occ   = count > CNT_W'(IDX);
  assign after = !occ || (ent_r.key > item.key);
  assign ge    = occ && (ent_r.key >= item.key);
  assign hit   = occ && (ent_r.key == item.key) && !left_ge;
  assign ent   = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins_en && after) begin
      ent_nxt = left_after ? left_ent : item;
    end else if (ctl.del_en && ge) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== design/skt_chain.sv =====
// Row of table cells with the match reduction for delete requests.
`timescale 1ns / 1ps

`include "sorted_key_table_assert.svh"

module skt_chain #(
  parameter int CAPACITY = 64,
  parameter int CNT_W    = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  skt_pkg::skt_ctl_t ctl,
  input  skt_pkg::entry_t   item,
  input  logic [CNT_W-1:0]  count,
  output logic              found
);

  skt_pkg::entry_t     ent   [CAPACITY];
  logic [CAPACITY-1:0] after_vec;
  logic [CAPACITY-1:0] ge_vec;
  logic [CAPACITY-1:0] hit_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skt_pkg::entry_t left_ent;
    skt_pkg::entry_t right_ent;
    logic            left_after;
    logic            left_ge;

    if (i == 0) begin : g_first
      assign left_ent   = '0;
      assign left_after = 1'b0;
      assign left_ge    = 1'b0;
    end else begin : g_mid
      assign left_ent   = ent[i-1];
      assign left_after = after_vec[i-1];
      assign left_ge    = ge_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    skt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .item       (item),
      .count      (count),
      .left_ent   (left_ent),
      .left_after (left_after),
      .left_ge    (left_ge),
      .right_ent  (right_ent),
      .ent        (ent[i]),
      .after      (after_vec[i]),
      .ge         (ge_vec[i]),
      .hit        (hit_vec[i])
    );
  end

  assign found = |hit_vec;

  // The table stays sorted, so each compare flag rises at most once along the row and at most one cell hits.
  `SKT_ASSERT_IMP(a_hit_single, 1'b1, $onehot0(hit_vec))
  `SKT_ASSERT_IMP(a_after_mono, 1'b1, $onehot0(after_vec & ~{after_vec[CAPACITY-2:0], 1'b0}))
  `SKT_ASSERT_IMP(a_ge_mono, 1'b1, $onehot0(ge_vec & ~{ge_vec[CAPACITY-2:0], 1'b0}))

endmodule

// ===== tb/skt_tb_pkg.sv =====
// Scoreboard class that predicts and checks the sorted key table results.
`timescale 1ns / 1ps

package skt_tb_pkg;

  import skt_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  class key_table_scoreboard;
    entry_t      slots[$];
    outcome_t    awaited[$];
    int unsigned capacity;
    int unsigned errors;

    function new(int unsigned cap);
      capacity = cap;
      errors   = 0;
    endfunction

    function void note_request(logic cmd, entry_t item);
      outcome_t    res;
      int unsigned pos;
      if (cmd == CMD_INSERT) begin
        if (slots.size() >= capacity) begin
          res.status = ST_FULL;
        end else begin
          pos = slots.size();
          while (pos > 0 && slots[pos-1].key > item.key) pos--;
          slots.insert(pos, item);
          res.status = ST_DONE;
        end
      end else begin
        pos = 0;
        while (pos < slots.size() && slots[pos].key != item.key) pos++;
        if (pos >= slots.size()) begin
          res.status = ST_NOT_FOUND;
        end else begin
          slots.delete(pos);
          res.status = ST_DONE;
        end
      end
      res.count = COUNT_W'(slots.size());
      awaited.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count);
      outcome_t want;
      if (awaited.size() == 0) begin
        $error("result with no request pending: status %0d count %0d", status, count);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function int unsigned stored();
      return slots.size();
    endfunction

    function logic [KEY_W-1:0] stored_key();
      return slots[$urandom_range(slots.size() - 1)].key;
    endfunction
  endclass

endpackage

// ===== tb/sorted_key_table_tb.sv =====
// Testbench top that drives the sorted key table with insert and delete requests.
`timescale 1ns / 1ps

module sorted_key_table_tb;

  import skt_pkg::*;
  import skt_tb_pkg::*;

  localparam int TABLE_DEPTH = 64;

  logic clk;
  logic rst_n;
  bit   calm;
  bit   hold_req;
  int   stall_left;

  skt_in_if  req_ch ();
  skt_out_if res_ch ();

  key_table_scoreboard sb = new(TABLE_DEPTH);

  sorted_key_table #(
    .CAPACITY(TABLE_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_res(res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready) begin
      sb.note_request(req_ch.cmd, '{req_ch.key, req_ch.value_pct, req_ch.name_ref});
    end
    if (rst_n && res_ch.valid && res_ch.ready) begin
      sb.check_result(res_ch.status, res_ch.count);
    end
  end

  initial begin
    res_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        stall_left   = 59;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] value_pct,
                              input logic [NAME_W-1:0] name_ref);
    if (!calm && $urandom_range(99) < 20) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= cmd;
    req_ch.key       <= key;
    req_ch.value_pct <= value_pct;
    req_ch.name_ref  <= name_ref;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_random(input int insert_pct);
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [VALUE_W-1:0] value_pct;
    cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
    key = KEY_W'($urandom);
    if (sb.stored() > 0) begin
      if (cmd == CMD_DELETE && $urandom_range(99) < 75) key = sb.stored_key();
      if (cmd == CMD_INSERT && $urandom_range(99) < 30) key = sb.stored_key();
    end
    if ($urandom_range(99) < 80) value_pct = VALUE_W'($urandom_range(10000));
    else value_pct = VALUE_W'($urandom);
    send_request(cmd, key, value_pct, $urandom);
  endtask

  initial begin
    rst_n            = 1'b0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.cmd       = CMD_INSERT;
    req_ch.key       = '0;
    req_ch.value_pct = '0;
    req_ch.name_ref  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(CMD_DELETE, 16'h0000, 14'd0, 32'h0);
    send_request(CMD_INSERT, 16'h8000, 14'd0, 32'h0000_0000);
    send_request(CMD_INSERT, 16'h0000, 14'd10000, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 16'hFFFF, 14'h3FFF, 32'hA5A5_A5A5);
    send_request(CMD_INSERT, 16'h8000, 14'd1, 32'h0000_0001);
    send_request(CMD_INSERT, 16'h8000, 14'd2, 32'h0000_0002);
    send_request(CMD_DELETE, 16'h8000, 14'h3FFF, 32'hFFFF_FFFF);
    send_request(CMD_DELETE, 16'h1234, 14'd0, 32'h0);
    send_request(CMD_DELETE, 16'hFFFF, 14'd0, 32'h0);
    send_request(CMD_DELETE, 16'h0000, 14'd0, 32'h0);
    send_request(CMD_DELETE, 16'h0000, 14'd0, 32'h0);
    send_request(CMD_INSERT, 16'h7FFF, 14'h2AAA, 32'h5555_5555);
    send_request(CMD_INSERT, 16'h0001, 14'h1555, 32'hAAAA_AAAA);
    send_request(CMD_DELETE, 16'h8000, 14'd0, 32'h0);
    send_request(CMD_DELETE, 16'h8000, 14'd0, 32'h0);

    // The table fills up here, so several inserts are refused as full.
    calm = 1'b1;
    repeat (60) send_random(90);
    calm = 1'b0;
    repeat (50) send_random(90);

    // The receiver holds off while requests keep coming, stalling the input.
    hold_req = 1'b1;
    repeat (120) send_random(35);
    repeat (120) send_random(60);
    repeat (100) send_random(20);

    req_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/skt_pkg.sv
design/skt_if.sv
design/skt_cell.sv
design/skt_chain.sv
design/sorted_key_table.sv
tb/skt_tb_pkg.sv
tb/sorted_key_table_tb.sv
